### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the text console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Delayed implication, sampled on the rising clock edge outside reset.
`define ASSERT_DELAY2(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("two-cycle implication failed");

`endif

### hw/rtl/tcw_pkg.sv
// Package of the text console writer: geometry, codes, request and result types.
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    // Field widths.
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W = 2 * CHAR_W;

    // Character codes and attribute layout.
    localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam int                BACK_SHIFT   = 4;

    // Operation codes.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // One request item.
    typedef struct packed {
        logic               opcode;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
    } t_request;

    // One result item.
    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
    } t_result;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic scr_read;
        logic scr_write;
        logic blank_write;
        logic emit_read;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll_needed;
        logic idx_last_copy;
        logic idx_last;
    } t_dp_status;

endpackage

`default_nettype wire

### hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       i_opcode,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            busy
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass over the cell store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == OP_READ) begin
                        n_state = ST_READ;
                    end else if (i_status.scroll_needed) begin
                        n_state = ST_SCR_RD;
                    end
                end
            end
            ST_READ: begin
                o_cmd.emit_read = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCR_RD: begin
                o_cmd.scr_read = 1'b1;
                n_state        = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                o_cmd.scr_write = 1'b1;
                n_state         = i_status.idx_last_copy ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                o_cmd.blank_write = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, sweep index and result register.
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_request i_request,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_status    o_status,
    output logic          o_strobe,
    output t_result       o_result
);

    localparam logic [COL_W:0]    COL_LIMIT  = (COL_W+1)'(SCREEN_WIDTH);
    localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W+1)'(SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0]  ROW_BOTTOM = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] IDX_STRIDE = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] IDX_LAST   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] IDX_COPY   = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * IDX_STRIDE + ADDR_W'(col);
    endfunction

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;
    logic              r_rd_ok;
    logic              n_rd_ok;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    logic              r_strobe;
    logic              n_strobe;
    t_result           r_result;
    t_result           n_result;

    logic [ROW_W:0]    w_row_inc;
    logic [COL_W:0]    w_col_inc;
    logic              w_is_put;
    logic              w_is_newline;
    logic              w_adv_row;
    logic              w_scroll;
    logic              w_read_in_range;
    logic [CHAR_W-1:0] w_attr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;

    // Decode of the request and the cursor advance it would cause.
    always_comb begin
        w_is_put        = (i_request.opcode == OP_PUT) && (i_request.char_code != NULL_CODE);
        w_is_newline    = (i_request.char_code == NEWLINE_CODE);
        w_row_inc       = {1'b0, r_row} + (ROW_W+1)'(1);
        w_col_inc       = {1'b0, r_col} + (COL_W+1)'(1);
        w_adv_row       = w_is_newline || (w_col_inc == COL_LIMIT);
        w_scroll        = w_adv_row && (w_row_inc == ROW_LIMIT);
        w_read_in_range = ((ROW_W+1)'(i_request.read_row) < ROW_LIMIT)
                       && ((COL_W+1)'(i_request.read_col) < COL_LIMIT);
        w_attr          = CHAR_W'(i_request.fore_color)
                        | (CHAR_W'(i_request.back_color) << BACK_SHIFT);
    end

    // Status toward the controller.
    always_comb begin
        o_status.scroll_needed = w_is_put && w_scroll;
        o_status.idx_last_copy = (r_idx == IDX_COPY);
        o_status.idx_last      = (r_idx == IDX_LAST);
    end

    // Cursor, sweep index and result updates.
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_idx    = r_idx;
        n_rd_ok  = r_rd_ok;
        n_strobe = 1'b0;
        n_result = r_result;
        if (i_cmd.accept && i_request.opcode == OP_READ) begin
            n_rd_ok = w_read_in_range;
        end else if (i_cmd.accept && w_is_put) begin
            if (w_scroll) begin
                n_row = ROW_BOTTOM;
                n_col = '0;
                n_idx = '0;
            end else if (w_adv_row) begin
                n_row = w_row_inc[ROW_W-1:0];
                n_col = '0;
            end else begin
                n_col = w_col_inc[COL_W-1:0];
            end
            n_strobe            = 1'b1;
            n_result.cursor_pos = POS_W'(cell_addr(n_row, n_col));
            n_result.cell_char  = '0;
            n_result.cell_attr  = '0;
        end
        if (i_cmd.emit_read) begin
            n_strobe            = 1'b1;
            n_result.cursor_pos = POS_W'(cell_addr(r_row, r_col));
            n_result.cell_char  = r_rd_ok ? r_rdata[CHAR_W-1:0] : '0;
            n_result.cell_attr  = r_rd_ok ? r_rdata[CELL_W-1:CHAR_W] : '0;
        end
        if (i_cmd.clr_step || i_cmd.scr_write || i_cmd.blank_write) begin
            n_idx = r_idx + ADDR_W'(1);
        end
    end

    // Store port selection: one write and one read address per cycle.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = r_idx + IDX_STRIDE;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end else if (i_cmd.scr_write) begin
            w_we    = 1'b1;
            w_wdata = r_rdata;
        end else if (i_cmd.blank_write) begin
            w_we    = 1'b1;
            w_wdata = {CHAR_W'(0), BLANK_CODE};
        end else if (i_cmd.scr_read) begin
            w_re = 1'b1;
        end else if (i_cmd.accept && i_request.opcode == OP_READ) begin
            w_re    = w_read_in_range;
            w_raddr = cell_addr(i_request.read_row, i_request.read_col);
        end else if (i_cmd.accept && w_is_put && !w_is_newline) begin
            w_we    = 1'b1;
            w_waddr = cell_addr(r_row, r_col);
            w_wdata = {w_attr, i_request.char_code};
        end
    end

    // Cell store with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_ok  <= n_rd_ok;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

### hw/rtl/text_console_writer_top.sv
// Top level of the text console writer.
`default_nettype none

// Text console writer over an 80 by 25 store of 16-bit cells (attribute, character).
// A request is taken at a rising edge where start is high and busy is low.
// A put request with a nonzero code writes the cell at the cursor (or handles a
// newline), advances the cursor and returns the new linear cursor position on
// o_result in the cycle after the request; a null code returns nothing.
// Puts that need no scroll keep busy low, so one put can be taken every cycle.
// A read request returns one stored cell and the cursor position through the read
// data register, ST_READ and the result register; busy is high for one cycle, in ST_READ.
// A put that runs past the bottom row scrolls the store through its single
// read and write port with busy high: each copied cell is read in ST_SCR_RD and
// written in ST_SCR_WR, then the bottom row is blanked cell by cell in ST_BLANK;
// the result of that put still comes in the cycle after the request.
// After reset a clearing pass writes zero to all 2000 cells, one per cycle,
// with busy high throughout; the cursor starts at row 0, column 0.
// o_strobe marks each result for exactly one cycle; the receiver cannot stall.
module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_request,
    output logic          busy,
    output logic          o_strobe,
    output t_result       o_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Controller.
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_request.opcode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // Datapath.
    tcw_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

### hw/rtl/tcw_checker.sv
// Port-level checker of the text console writer and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_start,
    input wire t_request i_request,
    input wire logic     i_busy,
    input wire logic     i_strobe,
    input wire t_result  i_result
);

    logic w_take;
    logic w_take_null;
    logic w_take_put;
    logic w_take_read_out;
    logic w_empty_cell;

    assign w_take          = i_start && !i_busy;
    assign w_take_null     = w_take && (i_request.opcode == OP_PUT)
                          && (i_request.char_code == NULL_CODE);
    assign w_take_put      = w_take && (i_request.opcode == OP_PUT)
                          && (i_request.char_code != NULL_CODE);
    assign w_take_read_out = w_take && (i_request.opcode == OP_READ)
                          && (i_request.read_col >= COL_W'(SCREEN_WIDTH));
    assign w_empty_cell    = (i_result.cell_char == '0) && (i_result.cell_attr == '0);

    // A reported cursor position always lies on the screen.
    `ASSERT_IMPLY(a_pos_on_screen, i_strobe, i_result.cursor_pos < POS_W'(CELL_COUNT))

    // A null put request produces no result.
    `ASSERT_NEXT(a_null_silent, w_take_null, !i_strobe)

    // Any other put request answers in the next cycle with an empty cell.
    `ASSERT_NEXT(a_put_answer, w_take_put, i_strobe && w_empty_cell)

    // A read with its column off the screen answers with an empty cell.
    `ASSERT_DELAY2(a_read_outside, w_take_read_out, i_strobe && w_empty_cell)

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (start),
    .i_request (i_request),
    .i_busy    (busy),
    .i_strobe  (o_strobe),
    .i_result  (o_result)
);

`default_nettype wire
